// ----- src/ppt_pkg.sv -----
// Shared constants and control types for the point-in-polygon test unit.
`timescale 1ns / 1ps

package ppt_pkg;

  // Default capacity and internal coordinate width.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 32;

  // Fixed widths of the port fields.
  localparam int IN_COORD_BITS = 32;
  localparam int VCOUNT_BITS   = 7;
  localparam int INDEX_BITS    = 6;

  // Transaction modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Token handed to the edge evaluator once per walk cycle.
  typedef struct packed {
    logic live;  // a real polygon edge is presented
    logic last;  // final token of the walk
  } edge_ctl_t;

  // Token leaving the edge evaluator.
  typedef struct packed {
    logic last;    // final token of the walk
    logic toggle;  // the edge crosses left of the point
  } edge_res_t;

endpackage

// ----- src/ppt_cell.sv -----
// One vertex cell of the rotating vertex ring.
`timescale 1ns / 1ps

module ppt_cell #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] load_x,
  input  logic signed [COORD_BITS-1:0] load_y,
  input  logic signed [COORD_BITS-1:0] next_x,
  input  logic signed [COORD_BITS-1:0] next_y,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y
);

  // A load writes the cell; otherwise a shift takes the neighbor's vertex.
  always_ff @(posedge clk) begin
    if (load) begin
      x <= load_x;
      y <= load_y;
    end else if (shift) begin
      x <= next_x;
      y <= next_y;
    end
  end

endmodule

// ----- src/ppt_mul.sv -----
// Two-stage signed multiplier built from four half-width partial products.
`timescale 1ns / 1ps

module ppt_mul #(
  parameter int W = 33
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int H  = (W + 1) / 2;
  localparam int L  = W - H;
  localparam int PW = 2 * W;

  logic        [H-1:0]   a_lo;
  logic        [H-1:0]   b_lo;
  logic signed [L-1:0]   a_hi;
  logic signed [L-1:0]   b_hi;
  logic        [2*H-1:0] pp_ll;
  logic signed [H+L:0]   pp_lh;
  logic signed [H+L:0]   pp_hl;
  logic signed [2*L-1:0] pp_hh;

  // The low halves are unsigned, the high halves carry the sign.
  assign a_lo = a[H-1:0];
  assign b_lo = b[H-1:0];
  assign a_hi = a[W-1:H];
  assign b_hi = b[W-1:H];

  // First stage: partial products.
  always_ff @(posedge clk) begin
    pp_ll <= a_lo * b_lo;
    pp_lh <= signed'({1'b0, a_lo}) * b_hi;
    pp_hl <= a_hi * signed'({1'b0, b_lo});
    pp_hh <= a_hi * b_hi;
  end

  // Second stage: weighted sum of the partial products.
  always_ff @(posedge clk) begin
    p <= (PW'(pp_hh) << (2 * H)) + (PW'(pp_lh) << H) + (PW'(pp_hl) << H) + PW'(pp_ll);
  end

endmodule

// ----- src/ppt_edge_eval.sv -----
// Pipelined crossing test of one polygon edge against the query point.
`timescale 1ns / 1ps

module ppt_edge_eval #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ppt_pkg::edge_ctl_t           ctl,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] xi,
  input  logic signed [COORD_BITS-1:0] yi,
  input  logic signed [COORD_BITS-1:0] xj,
  input  logic signed [COORD_BITS-1:0] yj,
  output ppt_pkg::edge_res_t           res
);

  import ppt_pkg::*;

  localparam int W = COORD_BITS + 1;

  typedef struct packed {
    logic live;
    logic last;
    logic den_neg;
  } stage_t;

  logic          straddle;
  logic          left_any;
  stage_t        s0;
  stage_t        s1;
  stage_t        s2;
  logic signed [W-1:0]   num;
  logic signed [W-1:0]   run;
  logic signed [W-1:0]   gap;
  logic signed [W-1:0]   den;
  logic signed [2*W-1:0] prod_a;
  logic signed [2*W-1:0] prod_b;
  logic                  less;

  // The edge straddles the point's y and at least one end is not right of it.
  assign straddle = ((yi < py) && (yj >= py)) || ((yj < py) && (yi >= py));
  assign left_any = (xi <= px) || (xj <= px);

  // Stage 0: differences and edge qualification.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0 <= '0;
    end else begin
      s0.live    <= ctl.live && straddle && left_any;
      s0.last    <= ctl.last;
      s0.den_neg <= (yj < yi);
    end
  end

  always_ff @(posedge clk) begin
    num <= W'(py) - W'(yi);
    run <= W'(xj) - W'(xi);
    gap <= W'(px) - W'(xi);
    den <= W'(yj) - W'(yi);
  end

  // Both sides of the cross-multiplied comparison.
  ppt_mul #(.W(W)) u_mul_a (
    .clk (clk),
    .a   (num),
    .b   (run),
    .p   (prod_a)
  );

  ppt_mul #(.W(W)) u_mul_b (
    .clk (clk),
    .a   (gap),
    .b   (den),
    .p   (prod_b)
  );

  // Control follows the two multiplier stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= s0;
      s2 <= s1;
    end
  end

  // A negative denominator reverses the sense of the comparison.
  assign less = s2.den_neg ? (prod_b < prod_a) : (prod_a < prod_b);

  // Final stage: crossing decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else begin
      res.last   <= s2.last;
      res.toggle <= s2.live && less;
    end
  end

endmodule

// ----- src/point_in_polygon_test_unit.sv -----
// Top level of the point-in-polygon test unit: vertex ring, walk control, result.
`timescale 1ns / 1ps

// A transaction is accepted when start is high and busy is low. A load (mode 0) writes
// one vertex in that cycle and returns no result; busy stays low. A query (mode 1)
// rotates the ring of MAX_VERTICES vertex cells once past a single pipelined edge
// evaluator, one edge per cycle; busy is high through the walk and the drain, and the
// inside_res result is shown with done for exactly one cycle, once the final edge token
// has left the evaluator; the next transaction may be accepted in that same cycle. The
// walk length is set by the ring capacity, not by vertex_count, and the evaluator adds
// four pipeline stages (difference, partial products, sum, compare).
// The receiver cannot stall: done must be sampled in the cycle it is high. Vertex
// slots that a query reaches must have been loaded; the user must write vertex_count
// only while busy is low; the block itself does not enforce this.
module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = ppt_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     mode,
  input  logic        [ppt_pkg::INDEX_BITS-1:0]    vertex_index,
  input  logic signed [ppt_pkg::IN_COORD_BITS-1:0] coord_x,
  input  logic signed [ppt_pkg::IN_COORD_BITS-1:0] coord_y,
  output logic                                     done,
  output logic                                     inside_res,
  input  logic                                     cfg_we,
  input  logic        [ppt_pkg::VCOUNT_BITS-1:0]   cfg_wdata
);

  import ppt_pkg::*;

  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam logic [NW-1:0] STEP_END = NW'(MAX_VERTICES);

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    DRAIN
  } state_t;

  state_t                     state;
  logic [NW-1:0]              step;
  logic [NW-1:0]              n_eff;
  logic [NW-1:0]              n_sat;
  logic                       parity;
  logic [VCOUNT_BITS-1:0]     vertex_count;
  logic                       load_fire;
  logic                       query_fire;
  logic                       shift;
  logic signed [63:0]         in_x_ext;
  logic signed [63:0]         in_y_ext;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cell_y [MAX_VERTICES];
  edge_ctl_t                  ctl;
  edge_res_t                  res;

  // Handshake decode.
  assign busy       = (state != IDLE);
  assign load_fire  = start && !busy && (mode == MODE_LOAD);
  assign query_fire = start && !busy && (mode == MODE_QUERY);

  // Coordinates are sign extended, then taken at the internal width.
  assign in_x_ext = 64'(coord_x);
  assign in_y_ext = 64'(coord_y);
  assign in_x     = in_x_ext[COORD_BITS-1:0];
  assign in_y     = in_y_ext[COORD_BITS-1:0];

  // A vertex count above the ring capacity saturates.
  assign n_sat = (32'(vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vertex_count);

  // Vertex count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // The ring rotates once per query and is back home when the walk ends.
  assign shift = (state == WALK) && (step != STEP_END);

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    localparam int NXT = (k + 1) % MAX_VERTICES;

    ppt_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk    (clk),
      .shift  (shift),
      .load   (load_fire && (32'(vertex_index) == k)),
      .load_x (in_x),
      .load_y (in_y),
      .next_x (cell_x[NXT]),
      .next_y (cell_y[NXT]),
      .x      (cell_x[k]),
      .y      (cell_y[k])
    );
  end

  // Step k presents edge (k-1, k); step n closes the polygon back to vertex 0.
  assign cur_x = (step == n_eff) ? first_x : cell_x[0];
  assign cur_y = (step == n_eff) ? first_y : cell_y[0];

  always_comb begin
    ctl = '0;
    if (state == WALK) begin
      ctl.live = (step != '0) && (step <= n_eff);
      ctl.last = (step == STEP_END);
    end
  end

  ppt_edge_eval #(.COORD_BITS(COORD_BITS)) u_eval (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .px  (px),
    .py  (py),
    .xi  (cur_x),
    .yi  (cur_y),
    .xj  (prev_x),
    .yj  (prev_y),
    .res (res)
  );

  // Query point, effective count and the vertices kept beside the ring head.
  always_ff @(posedge clk) begin
    if (query_fire) begin
      px    <= in_x;
      py    <= in_y;
      n_eff <= n_sat;
    end
    if (state == WALK) begin
      prev_x <= cell_x[0];
      prev_y <= cell_y[0];
      if (step == '0) begin
        first_x <= cell_x[0];
        first_y <= cell_y[0];
      end
    end
  end

  // Walk control, crossing parity and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      step       <= '0;
      parity     <= 1'b0;
      done       <= 1'b0;
      inside_res <= 1'b0;
    end else begin
      done <= (state == DRAIN) && res.last;
      case (state)
        IDLE: begin
          if (query_fire) begin
            state  <= WALK;
            step   <= '0;
            parity <= 1'b0;
          end
        end
        WALK: begin
          parity <= parity ^ res.toggle;
          if (step == STEP_END) begin
            state <= DRAIN;
          end else begin
            step <= step + NW'(1);
          end
        end
        DRAIN: begin
          if (res.last) begin
            inside_res <= parity ^ res.toggle;
            state      <= IDLE;
          end else begin
            parity <= parity ^ res.toggle;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The final evaluator token only ever arrives while draining.
  a_last_in_drain: assert property (@(posedge clk) disable iff (rst)
    res.last |-> (state == DRAIN))
    else $error("final edge token arrived outside the drain phase");

  // A result is only produced at the end of a drain.
  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == DRAIN))
    else $error("result strobe without a finished walk");

  // The unit is free to accept again when the result is shown.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  // The walk never runs past one full ring rotation.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == WALK) |-> (step <= STEP_END))
    else $error("walk step beyond ring length");

endmodule

// ----- tb/tb_point_in_polygon_test_unit.sv -----
// Self-checking testbench for the point-in-polygon test unit.
`timescale 1ns / 1ps

module tb_point_in_polygon_test_unit;
  import ppt_pkg::*;

  localparam int MAXV        = MAX_VERTICES_DEF;
  localparam int SETTLE      = MAXV + 8;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic                             busy;
  logic                             mode;
  logic        [INDEX_BITS-1:0]     vertex_index;
  logic signed [IN_COORD_BITS-1:0]  coord_x;
  logic signed [IN_COORD_BITS-1:0]  coord_y;
  logic                             done;
  logic                             inside_res;
  logic                             cfg_we;
  logic        [VCOUNT_BITS-1:0]    cfg_wdata;

  // Mirror of the polygon held by the block, and the expected inside flags.
  logic signed [31:0]      poly_x [MAXV];
  logic signed [31:0]      poly_y [MAXV];
  logic [VCOUNT_BITS-1:0]  poly_count;
  logic                    inside_flags_q [$];
  logic                    expected_flag;
  int                      mismatch_count;
  int                      idle_pct;
  int                      items_sent;

  point_in_polygon_test_unit uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .done         (done),
    .inside_res   (inside_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Crossing-number test with exact cross-multiplication.
  function automatic logic polygon_contains(input logic signed [31:0] px,
                                            input logic signed [31:0] py);
    int n;
    int j;
    logic in_poly;
    logic straddle;
    logic signed [31:0] xi, yi, xj, yj;
    longint num, run, den, gap;
    logic signed [127:0] num_w, run_w, den_w, gap_w;
    n = (poly_count > MAXV) ? MAXV : int'(poly_count);
    in_poly = 1'b0;
    if (n == 0) return 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      straddle = (yi < py && yj >= py) || (yj < py && yi >= py);
      if (straddle && (xi <= px || xj <= px)) begin
        num = longint'(py) - longint'(yi);
        run = longint'(xj) - longint'(xi);
        den = longint'(yj) - longint'(yi);
        gap = longint'(px) - longint'(xi);
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        num_w = num;
        run_w = run;
        den_w = den;
        gap_w = gap;
        if ((num_w * run_w) < (gap_w * den_w)) in_poly = ~in_poly;
      end
      j = i;
    end
    return in_poly;
  endfunction

  // Coordinate source: tiny range for ties, moderate range, full range, extremes.
  function automatic logic signed [31:0] rand_coord(input int scale);
    case (scale)
      0: return 32'(int'($urandom_range(0, 8)) - 4);
      1: return 32'(int'($urandom_range(0, 4000)) - 2000);
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 9))
          0: return CMIN;
          1: return CMAX;
          2: return 32'sd0;
          3: return -32'sd1;
          4: return CMIN + 32'sd1;
          5: return CMAX - 32'sd1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Sends one transaction after a random idle gap and records its effect.
  task automatic send_item(input logic m, input logic [5:0] idx,
                           input logic signed [31:0] x, input logic signed [31:0] y);
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      @(negedge clk);
      start        = 1'b0;
      mode         = 1'($urandom);
      vertex_index = INDEX_BITS'($urandom);
      coord_x      = $urandom;
      coord_y      = $urandom;
    end
    @(negedge clk);
    start        = 1'b1;
    mode         = m;
    vertex_index = idx;
    coord_x      = x;
    coord_y      = y;
    do @(posedge clk); while (busy);
    items_sent++;
    if (m == MODE_LOAD) begin
      poly_x[idx] = x;
      poly_y[idx] = y;
    end else begin
      inside_flags_q.push_back(polygon_contains(x, y));
    end
  endtask

  // Holds the sender until every expected result has come and the block is quiet.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (inside_flags_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [VCOUNT_BITS-1:0] value);
    @(negedge clk);
    start      = 1'b0;
    cfg_we     = 1'b1;
    cfg_wdata  = value;
    poly_count = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = VCOUNT_BITS'($urandom);
  endtask

  // Every slot holds a vertex, so no query ever reads an unwritten one.
  task automatic load_all_slots(input int scale);
    for (int k = 0; k < MAXV; k++)
      send_item(MODE_LOAD, 6'(k), rand_coord(scale), rand_coord(scale));
  endtask

  task automatic test_empty_polygon();
    wait_idle();
    write_vertex_count(7'd0);
    send_item(MODE_QUERY, 6'd0, 32'sd0, 32'sd0);
    send_item(MODE_QUERY, 6'd63, CMIN, CMAX);
  endtask

  task automatic test_square();
    wait_idle();
    send_item(MODE_LOAD, 6'd0, -32'sd1000, -32'sd1000);
    send_item(MODE_LOAD, 6'd1, 32'sd1000, -32'sd1000);
    send_item(MODE_LOAD, 6'd2, 32'sd1000, 32'sd1000);
    send_item(MODE_LOAD, 6'd3, -32'sd1000, 32'sd1000);
    write_vertex_count(7'd4);
    send_item(MODE_QUERY, 6'd0, 32'sd0, 32'sd0);
    send_item(MODE_QUERY, 6'd5, 32'sd2000, 32'sd0);
    send_item(MODE_QUERY, 6'd0, -32'sd1000, 32'sd0);
    send_item(MODE_QUERY, 6'd0, 32'sd1000, 32'sd0);
    send_item(MODE_QUERY, 6'd0, 32'sd0, -32'sd1000);
    send_item(MODE_QUERY, 6'd0, 32'sd0, 32'sd1000);
    send_item(MODE_QUERY, 6'd0, -32'sd1000, -32'sd1000);
  endtask

  // Corners of the coordinate range stress the width of the products.
  task automatic test_extreme_corners();
    wait_idle();
    send_item(MODE_LOAD, 6'd0, CMIN, CMIN);
    send_item(MODE_LOAD, 6'd1, CMAX, CMIN);
    send_item(MODE_LOAD, 6'd2, CMAX, CMAX);
    send_item(MODE_LOAD, 6'd3, CMIN, CMAX);
    send_item(MODE_LOAD, 6'd4, 32'sd0, 32'sd0);
    write_vertex_count(7'd5);
    send_item(MODE_QUERY, 6'd0, 32'sd0, 32'sd1);
    send_item(MODE_QUERY, 6'd0, CMIN, CMIN);
    send_item(MODE_QUERY, 6'd0, CMAX, CMAX);
    send_item(MODE_QUERY, 6'd0, CMIN, 32'sd0);
    send_item(MODE_QUERY, 6'd0, CMAX, -32'sd1);
  endtask

  // One and two vertices: nothing or a doubled segment to cross.
  task automatic test_degenerate_counts();
    wait_idle();
    write_vertex_count(7'd1);
    send_item(MODE_QUERY, 6'd0, CMIN, CMIN);
    wait_idle();
    write_vertex_count(7'd2);
    send_item(MODE_QUERY, 6'd0, CMAX, CMAX - 32'sd1);
    send_item(MODE_QUERY, 6'd0, 32'sd0, 32'sd0);
  endtask

  // Counts above the capacity saturate to the full ring.
  task automatic test_count_saturation();
    logic [VCOUNT_BITS-1:0] counts [3];
    counts = '{7'd127, 7'd65, 7'd64};
    wait_idle();
    load_all_slots(1);
    foreach (counts[c]) begin
      wait_idle();
      write_vertex_count(counts[c]);
      send_item(MODE_QUERY, 6'd0, 32'sd0, 32'sd0);
      send_item(MODE_QUERY, 6'd0, rand_coord(1), rand_coord(1));
    end
  endtask

  // Random polygons, each loaded and then probed with points of the same scale.
  task automatic test_random_polygons(input int pct, input int quota);
    int stop_at;
    int r;
    int scale;
    int n_cfg;
    int n_load;
    int n_query;
    stop_at  = items_sent + quota;
    idle_pct = pct;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 5)       n_cfg = $urandom_range(0, 2);
      else if (r < 85) n_cfg = $urandom_range(3, 12);
      else if (r < 95) n_cfg = $urandom_range(13, 40);
      else             n_cfg = $urandom_range(64, 127);
      n_load = (n_cfg > MAXV) ? MAXV : n_cfg;
      scale  = $urandom_range(0, 3);
      wait_idle();
      write_vertex_count(7'(n_cfg));
      for (int k = 0; k < n_load; k++)
        send_item(MODE_LOAD, 6'(k), rand_coord(scale), rand_coord(scale));
      n_query = $urandom_range(8, 24);
      for (int q = 0; q < n_query; q++) begin
        // Now and then move a vertex, or let the queue run dry mid-polygon.
        if ($urandom_range(0, 9) == 0)
          send_item(MODE_LOAD, 6'($urandom_range(0, MAXV - 1)),
                    rand_coord(scale), rand_coord(scale));
        if ($urandom_range(0, 19) == 0) wait_idle();
        send_item(MODE_QUERY, 6'($urandom), rand_coord(scale), rand_coord(scale));
      end
    end
    idle_pct = 0;
  endtask

  // Result checker: every done strobe must match the oldest expected flag.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (inside_flags_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result transaction, expected none, actual inside_res=%0b",
                 $time, inside_res);
      end else begin
        expected_flag = inside_flags_q.pop_front();
        if (inside_res !== expected_flag) begin
          mismatch_count++;
          $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                   $time, expected_flag, inside_res);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    mode           = MODE_LOAD;
    vertex_index   = '0;
    coord_x        = '0;
    coord_y        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    poly_count     = '0;
    mismatch_count = 0;
    idle_pct       = 0;
    items_sent     = 0;
    for (int k = 0; k < MAXV; k++) begin
      poly_x[k] = '0;
      poly_y[k] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    load_all_slots(2);
    test_empty_polygon();
    test_square();
    test_extreme_corners();
    test_degenerate_counts();
    test_count_saturation();
    test_random_polygons(0, 310);
    test_random_polygons(61, 310);
    test_random_polygons(0, 310);
    test_random_polygons(17, 310);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ppt_pkg.sv
src/ppt_cell.sv
src/ppt_mul.sv
src/ppt_edge_eval.sv
src/point_in_polygon_test_unit.sv
tb/tb_point_in_polygon_test_unit.sv
